[hw/rtl/spd_pkg.sv]
// Shared types and constants of the slotted page directory.
// Holds opcode and status codes, the command word and the default sizes.
// Depends on nothing.
`timescale 1ns / 1ps

package spd_pkg;

    localparam int HEADER_BYTES_DEF     = 24;
    localparam int SLOT_ENTRY_BYTES_DEF = 4;
    localparam int MAX_SLOTS_DEF        = 1024;

    localparam logic [15:0] PAGE_BYTES_RESET = 16'd4096;
    localparam logic [15:0] MIN_PAGE_BYTES   = 16'd128;
    localparam logic [15:0] MAX_PAGE_BYTES   = 16'd32768;

    typedef enum logic [2:0] {
        OP_INIT   = 3'd0,
        OP_INSERT = 3'd1,
        OP_GET    = 3'd2,
        OP_DELETE = 3'd3,
        OP_UPDATE = 3'd4
    } t_opcode;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

endpackage

[hw/rtl/slotted_page_directory.sv]
// Slotted page directory: one word in, one result word out.
// An accepted word reads its slot entry in the accept cycle and then executes once the result
// register is free or being read; a new word is taken only after the previous one executes.
// The result register lets the next word be accepted while a result still waits.
// Synchronous active-low reset: page size 4096, empty page, slot table contents undefined.
`timescale 1ns / 1ps

module slotted_page_directory
    import spd_pkg::*;
#(
    parameter int HEADER_BYTES     = HEADER_BYTES_DEF,
    parameter int SLOT_ENTRY_BYTES = SLOT_ENTRY_BYTES_DEF,
    parameter int MAX_SLOTS        = MAX_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_slot_index,
    input  logic [15:0] i_tuple_length_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_slot_number,
    output logic [15:0] o_tuple_offset,
    output logic [15:0] o_tuple_length,
    output logic [15:0] o_free_space
);

    t_cmd cmd;

    spd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    spd_datapath #(
        .HEADER_BYTES     (HEADER_BYTES),
        .SLOT_ENTRY_BYTES (SLOT_ENTRY_BYTES),
        .MAX_SLOTS        (MAX_SLOTS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_opcode          (i_opcode),
        .i_slot_index      (i_slot_index),
        .i_tuple_length_in (i_tuple_length_in),
        .o_status          (o_status),
        .o_slot_number     (o_slot_number),
        .o_tuple_offset    (o_tuple_offset),
        .o_tuple_length    (o_tuple_length),
        .o_free_space      (o_free_space)
    );

endmodule

[hw/rtl/spd_ram.sv]
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module spd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/spd_ctrl.sv]
// Controller of the slotted page directory: accept, execute and hand-off sequencing.
// Depends on spd_pkg for the command word.
`timescale 1ns / 1ps

module spd_ctrl
    import spd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd.capture = (r_state == S_IDLE) && i_in_valid;
        cmd.commit  = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
        n_state     = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (cmd.capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (cmd.commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    a_capture_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> (r_state == S_EXEC))
        else $error("accepted word did not start execution");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> r_out_valid)
        else $error("committed word not presented");

    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && r_out_valid && i_out_stall |=> (r_state == S_EXEC))
        else $error("execution finished while result register was occupied");

endmodule

[hw/rtl/spd_datapath.sv]
// Datapath of the slotted page directory: page pointers, slot table and result register.
// Depends on spd_pkg and spd_ram.
`timescale 1ns / 1ps

module spd_datapath
    import spd_pkg::*;
#(
    parameter int HEADER_BYTES     = HEADER_BYTES_DEF,
    parameter int SLOT_ENTRY_BYTES = SLOT_ENTRY_BYTES_DEF,
    parameter int MAX_SLOTS        = MAX_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_slot_index,
    input  logic [15:0] i_tuple_length_in,
    output logic [1:0]  o_status,
    output logic [15:0] o_slot_number,
    output logic [15:0] o_tuple_offset,
    output logic [15:0] o_tuple_length,
    output logic [15:0] o_free_space
);

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int UW = $clog2(MAX_SLOTS + 1);

    logic [15:0] r_page_bytes;
    logic [15:0] r_data_end, n_data_end;
    logic [15:0] r_sas, n_sas;
    logic [UW-1:0] r_used, n_used;
    logic [2:0]  r_op;
    logic [15:0] r_slot;
    logic [15:0] r_len;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_rslot, n_rslot;
    logic [15:0] r_roff, n_roff;
    logic [15:0] r_rlen, n_rlen;
    logic [15:0] r_free, n_free;

    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic [31:0]   rdata;
    logic [15:0]   gap, eoff, elen, page_clamped;
    logic          found;

    spd_ram #(
        .WIDTH (32),
        .DEPTH (MAX_SLOTS)
    ) u_slot_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (i_slot_index[AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        gap   = (r_sas <= r_data_end) ? 16'd0 : (r_sas - r_data_end);
        eoff  = rdata[15:0];
        elen  = rdata[31:16];
        found = (r_slot < 16'(r_used)) && (elen != 16'd0);
        if (r_page_bytes < MIN_PAGE_BYTES) begin
            page_clamped = MIN_PAGE_BYTES;
        end else if (r_page_bytes > MAX_PAGE_BYTES) begin
            page_clamped = MAX_PAGE_BYTES;
        end else begin
            page_clamped = r_page_bytes;
        end

        n_data_end = r_data_end;
        n_sas      = r_sas;
        n_used     = r_used;
        n_status   = ST_OK;
        n_rslot    = 16'd0;
        n_roff     = 16'd0;
        n_rlen     = 16'd0;
        we         = 1'b0;
        waddr      = r_slot[AW-1:0];
        wdata      = {r_len, r_data_end};

        case (r_op) inside
            OP_INIT: begin
                n_data_end = 16'(HEADER_BYTES);
                n_sas      = page_clamped;
                n_used     = '0;
            end
            OP_INSERT: begin
                if ((r_used == UW'(MAX_SLOTS)) ||
                    ({1'b0, gap} < ({1'b0, r_len} + 17'(SLOT_ENTRY_BYTES)))) begin
                    n_status = ST_FULL;
                end else begin
                    we         = 1'b1;
                    waddr      = r_used[AW-1:0];
                    wdata      = {r_len, r_data_end};
                    n_sas      = r_sas - 16'(SLOT_ENTRY_BYTES);
                    n_data_end = r_data_end + r_len;
                    n_used     = r_used + UW'(1);
                    n_rslot    = 16'(r_used);
                    n_roff     = r_data_end;
                    n_rlen     = r_len;
                end
            end
            OP_GET, OP_DELETE, OP_UPDATE: begin
                if (!found) begin
                    n_status = ST_NOT_FOUND;
                end else if (r_op == OP_GET) begin
                    n_roff = eoff;
                    n_rlen = elen;
                end else if (r_op == OP_DELETE) begin
                    we    = 1'b1;
                    wdata = {16'd0, eoff};
                end else if (r_len <= elen) begin
                    we     = 1'b1;
                    wdata  = {r_len, eoff};
                    n_roff = eoff;
                    n_rlen = r_len;
                end else if (gap < r_len) begin
                    n_status = ST_FULL;
                end else begin
                    we         = 1'b1;
                    wdata      = {r_len, r_data_end};
                    n_roff     = r_data_end;
                    n_rlen     = r_len;
                    n_data_end = r_data_end + r_len;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase

        n_free = (n_sas <= n_data_end) ? 16'd0 : (n_sas - n_data_end);
        we     = we && i_cmd.commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_bytes <= PAGE_BYTES_RESET;
            r_data_end   <= 16'(HEADER_BYTES);
            r_sas        <= PAGE_BYTES_RESET;
            r_used       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_page_bytes <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_data_end <= n_data_end;
                r_sas      <= n_sas;
                r_used     <= n_used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_slot <= i_slot_index;
            r_len  <= i_tuple_length_in;
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_rslot  <= n_rslot;
            r_roff   <= n_roff;
            r_rlen   <= n_rlen;
            r_free   <= n_free;
        end
    end

    assign o_status       = r_status;
    assign o_slot_number  = r_rslot;
    assign o_tuple_offset = r_roff;
    assign o_tuple_length = r_rlen;
    assign o_free_space   = r_free;

    a_pointers_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_data_end <= r_sas)
        else $error("data end passed the slot array");

    a_slots_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(MAX_SLOTS))
        else $error("slot count beyond table size");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit |-> !we)
        else $error("slot table written outside a commit");

endmodule

[verif/tb_slotted_page_directory.sv]
// Self-checking testbench for the slotted page directory: directed and random page operations.
// Predicts every result word from its own page model and checks it field by field.
// Depends on spd_pkg and slotted_page_directory.
`timescale 1ns / 1ps

module tb_slotted_page_directory;
    import spd_pkg::*;

    localparam logic [2:0]  OP_RESERVED_LO   = 3'd5;
    localparam logic [2:0]  OP_RESERVED_HI   = 3'd7;
    localparam int unsigned WORD_TARGET      = 1550;
    localparam int unsigned LONG_HOLD_CYCLES = 150;
    localparam int unsigned MAX_WAIT         = 14;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] slot_number;
        logic [15:0] tuple_offset;
        logic [15:0] tuple_length;
        logic [15:0] free_space;
    } t_page_result;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  opcode;
    logic [15:0] slot_index;
    logic [15:0] length_in;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [15:0] slot_number;
    logic [15:0] tuple_offset;
    logic [15:0] tuple_length;
    logic [15:0] free_space;

    // Page model state.
    logic [15:0] page_size_q;
    int unsigned data_end_q;
    int unsigned dir_start_q;
    int unsigned slot_count_q;
    logic [15:0] slot_off_q [MAX_SLOTS_DEF];
    logic [15:0] slot_len_q [MAX_SLOTS_DEF];

    t_page_result pending_results [$];
    int unsigned  error_count;
    int unsigned  words_sent;
    int unsigned  results_checked;
    int unsigned  page_sizes_used;
    int unsigned  outcome_tally [3];
    bit           sender_idle;
    bit           receiver_idle;
    bit           long_hold_request;

    slotted_page_directory DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_opcode          (opcode),
        .i_slot_index      (slot_index),
        .i_tuple_length_in (length_in),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_status          (status),
        .o_slot_number     (slot_number),
        .o_tuple_offset    (tuple_offset),
        .o_tuple_length    (tuple_length),
        .o_free_space      (free_space)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned free_bytes();
        if (dir_start_q <= data_end_q) return 0;
        return dir_start_q - data_end_q;
    endfunction

    function automatic t_page_result predict_page_op(logic [2:0] op, logic [15:0] slot,
                                                     logic [15:0] len);
        t_page_result r;
        logic [15:0]  size;
        logic [15:0]  eoff;
        logic [15:0]  elen;
        r = '0;
        case (op) inside
            OP_INIT: begin
                size = page_size_q;
                if (size < MIN_PAGE_BYTES) size = MIN_PAGE_BYTES;
                if (size > MAX_PAGE_BYTES) size = MAX_PAGE_BYTES;
                data_end_q   = HEADER_BYTES_DEF;
                dir_start_q  = 32'(size);
                slot_count_q = 0;
            end
            OP_INSERT: begin
                if (slot_count_q >= MAX_SLOTS_DEF
                        || free_bytes() < int'(len) + SLOT_ENTRY_BYTES_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    dir_start_q -= SLOT_ENTRY_BYTES_DEF;
                    slot_off_q[slot_count_q] = data_end_q[15:0];
                    slot_len_q[slot_count_q] = len;
                    r.slot_number  = slot_count_q[15:0];
                    r.tuple_offset = data_end_q[15:0];
                    r.tuple_length = len;
                    data_end_q += 32'(len);
                    slot_count_q++;
                end
            end
            OP_GET, OP_DELETE, OP_UPDATE: begin
                if (slot >= slot_count_q || slot_len_q[slot] == 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    eoff = slot_off_q[slot];
                    elen = slot_len_q[slot];
                    if (op == OP_GET) begin
                        r.tuple_offset = eoff;
                        r.tuple_length = elen;
                    end else if (op == OP_DELETE) begin
                        slot_len_q[slot] = '0;
                    end else if (len <= elen) begin
                        slot_len_q[slot] = len;
                        r.tuple_offset   = eoff;
                        r.tuple_length   = len;
                    end else if (free_bytes() < 32'(len)) begin
                        r.status = ST_FULL;
                    end else begin
                        slot_off_q[slot] = data_end_q[15:0];
                        slot_len_q[slot] = len;
                        r.tuple_offset   = data_end_q[15:0];
                        r.tuple_length   = len;
                        data_end_q += 32'(len);
                    end
                end
            end
            default: ;
        endcase
        r.free_space = 16'(free_bytes());
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Result checker.
    always @(posedge clk) begin
        t_page_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("Result word arrived with nothing expected (status %0d).", status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 16'(want.status), 16'(status));
                check_field("slot_number", want.slot_number, slot_number);
                check_field("tuple_offset", want.tuple_offset, tuple_offset);
                check_field("tuple_length", want.tuple_length, tuple_length);
                check_field("free_space", want.free_space, free_space);
                outcome_tally[want.status]++;
                results_checked++;
            end
        end
    end

    // Result receiver: random stall before each word while receiver_idle is set, or one long hold on request.
    always begin
        int unsigned hold;
        @(negedge clk);
        if (long_hold_request) begin
            hold = LONG_HOLD_CYCLES;
            long_hold_request = 1'b0;
        end else begin
            hold = receiver_idle ? $urandom_range(0, MAX_WAIT) : 0;
        end
        if (hold != 0) begin
            out_stall = 1'b1;
            repeat (hold) @(negedge clk);
        end
        out_stall = 1'b0;
        do @(posedge clk); while (!(rst_n && out_valid));
    end

    // Entered and left at a falling edge.
    task automatic send_word(input logic [2:0] op, input logic [15:0] slot,
                             input logic [15:0] len);
        int unsigned gap;
        gap = sender_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        opcode     = op;
        slot_index = slot;
        length_in  = len;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(predict_page_op(op, slot, len));
        words_sent++;
        @(negedge clk);
    endtask

    task automatic settle_page();
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_page_size(input logic [15:0] size);
        settle_page();
        cfg_we      = 1'b1;
        cfg_wdata   = size;
        page_size_q = size;
        @(negedge clk);
        cfg_we = 1'b0;
        page_sizes_used++;
    endtask

    function automatic logic [15:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 16'($urandom);
        if (roll < 3) return 16'($urandom_range(0, free_bytes()));
        return 16'($urandom_range(0, 48));
    endfunction

    function automatic logic [15:0] pick_slot();
        if ($urandom_range(0, 9) < 8) return 16'($urandom_range(0, slot_count_q));
        return 16'($urandom);
    endfunction

    task automatic send_random_word();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) send_word(OP_INIT, pick_slot(), pick_length());
        else if (roll < 38) send_word(OP_INSERT, pick_slot(), pick_length());
        else if (roll < 60) send_word(OP_GET, pick_slot(), pick_length());
        else if (roll < 72) send_word(OP_DELETE, pick_slot(), pick_length());
        else if (roll < 92) send_word(OP_UPDATE, pick_slot(), pick_length());
        else if (roll < 95)
            send_word(3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI)), pick_slot(),
                      pick_length());
        else send_word(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
    endtask

    task automatic test_basic_ops();
        send_word(OP_GET, 16'd0, 16'd0);
        send_word(OP_INSERT, 16'd0, 16'd0);
        send_word(OP_GET, 16'd0, 16'd0);
        send_word(OP_INSERT, 16'd0, 16'hFFFF);
        send_word(OP_INSERT, 16'd0, 16'd100);
        send_word(OP_GET, 16'd1, 16'd0);
        send_word(OP_UPDATE, 16'd1, 16'd40);
        send_word(OP_UPDATE, 16'd1, 16'd300);
        send_word(OP_UPDATE, 16'd1, 16'hFFFF);
        send_word(OP_DELETE, 16'd1, 16'd0);
        send_word(OP_DELETE, 16'd1, 16'd0);
        send_word(OP_UPDATE, 16'd1, 16'd10);
        send_word(OP_GET, 16'd2, 16'd0);
        send_word(OP_DELETE, 16'hFFFF, 16'hFFFF);
        send_word(OP_INSERT, 16'd0, 16'(free_bytes() - SLOT_ENTRY_BYTES_DEF));
        send_word(OP_INSERT, 16'd0, 16'd0);
        send_word(OP_UPDATE, 16'd2, 16'd0);
        send_word(OP_GET, 16'd2, 16'd0);
        for (int op = OP_RESERVED_LO; op <= OP_RESERVED_HI; op++)
            send_word(3'(op), 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_page_size_clamp();
        logic [15:0] sizes [4];
        sizes = '{16'd0, 16'hFFFF, MIN_PAGE_BYTES, MAX_PAGE_BYTES};
        foreach (sizes[i]) begin
            write_page_size(sizes[i]);
            send_word(OP_INIT, 16'd0, 16'd0);
            send_word(OP_INSERT, 16'd0, 16'(free_bytes() - SLOT_ENTRY_BYTES_DEF));
        end
    endtask

    task automatic test_slot_exhaustion();
        write_page_size(MAX_PAGE_BYTES);
        send_word(OP_INIT, 16'd0, 16'd0);
        for (int i = 0; i < MAX_SLOTS_DEF + 3; i++)
            send_word(OP_INSERT, 16'($urandom), 16'($urandom_range(0, 20)));
        send_word(OP_GET, 16'(MAX_SLOTS_DEF - 1), 16'd0);
        send_word(OP_UPDATE, 16'(MAX_SLOTS_DEF - 1), 16'd200);
        send_word(OP_DELETE, 16'(MAX_SLOTS_DEF - 1), 16'd0);
        send_word(OP_GET, 16'(MAX_SLOTS_DEF), 16'd0);
    endtask

    task automatic test_output_backpressure();
        settle_page();
        send_word(OP_INIT, 16'd0, 16'd0);
        sender_idle       = 1'b0;
        long_hold_request = 1'b1;
        repeat (30) send_random_word();
        sender_idle = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [15:0] size;
        while (words_sent < WORD_TARGET) begin
            case ($urandom_range(0, 5))
                0: size = 16'($urandom);
                1: size = 16'(MIN_PAGE_BYTES - 1);
                2: size = 16'(MAX_PAGE_BYTES + 1);
                default: size = 16'($urandom_range(MIN_PAGE_BYTES, MAX_PAGE_BYTES));
            endcase
            write_page_size(size);
            sender_idle   = $urandom_range(0, 3) != 0;
            receiver_idle = $urandom_range(0, 3) != 0;
            send_word(OP_INIT, 16'($urandom), 16'($urandom));
            repeat (60) send_random_word();
        end
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        in_valid          = 1'b0;
        out_stall         = 1'b0;
        opcode            = OP_INIT;
        slot_index        = '0;
        length_in         = '0;
        sender_idle       = 1'b1;
        receiver_idle     = 1'b1;
        long_hold_request = 1'b0;
        error_count       = 0;
        words_sent        = 0;
        results_checked   = 0;
        page_sizes_used   = 0;
        outcome_tally     = '{0, 0, 0};
        page_size_q       = PAGE_BYTES_RESET;
        data_end_q        = HEADER_BYTES_DEF;
        dir_start_q       = 32'(PAGE_BYTES_RESET);
        slot_count_q      = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_basic_ops();
        test_page_size_clamp();
        test_slot_exhaustion();
        test_output_backpressure();
        test_random_traffic();

        settle_page();
        repeat (10) @(negedge clk);
        $display("Run covered %0d words over %0d page sizes; %0d results checked.",
                 words_sent, page_sizes_used, results_checked);
        $display("Outcomes seen: %0d ok, %0d full, %0d not found.",
                 outcome_tally[ST_OK], outcome_tally[ST_FULL], outcome_tally[ST_NOT_FOUND]);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
